/* rtl/job_table_with_id_allocation_core_macros.svh */
// Assertion macros used by the job table checker.
`ifndef JOB_TABLE_WITH_ID_ALLOCATION_CORE_MACROS_SVH
`define JOB_TABLE_WITH_ID_ALLOCATION_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define JT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("job table check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define JT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("job table check failed");

`endif

/* rtl/jt_pkg.sv */
// Shared constants and types of the job table.
package jt_pkg;

    localparam int PID_W    = 22;
    localparam int JID_W    = 16;
    localparam int KIND_W   = 3;
    localparam int STATE_W  = 2;
    localparam int STATUS_W = 2;

    localparam int SLOT_COUNT_DEF  = 16;
    localparam int JOB_ID_BITS_DEF = 16;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_ADD      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIND_PID = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIND_JID = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FG       = 3'd4;

    // Run states
    localparam logic [STATE_W-1:0] ST_NONE = 2'd0;
    localparam logic [STATE_W-1:0] ST_FG   = 2'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ID    = 2'd3;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic              clear;
        logic [KIND_W-1:0] kind;
    } scan_ctl_t;

endpackage

/* rtl/jt_slot_ram.sv */
// Slot memory: one write port, one registered read port, per-entry valid bits.
module jt_slot_ram #(
    parameter int DEPTH  = jt_pkg::SLOT_COUNT_DEF,
    parameter int DATA_W = 40
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic                     rd_vld,
    output logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic [DATA_W-1:0]        rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] mem_q_reg;
    logic [DEPTH-1:0]  slot_vld_reg;
    logic              entry_vld_reg;
    logic              rd_vld_reg;
    logic [AW-1:0]     rd_idx_reg;

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Track written entries; an unwritten entry reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg  <= '0;
            entry_vld_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                slot_vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= rd_en;
            if (rd_en)
            begin
                entry_vld_reg <= slot_vld_reg[rd_addr];
                rd_idx_reg    <= rd_addr;
            end
        end
    end

    assign rd_vld  = rd_vld_reg;
    assign rd_idx  = rd_idx_reg;
    assign rd_data = entry_vld_reg ? mem_q_reg : '0;

endmodule

/* rtl/jt_scan.sv */
// Scan unit: finds the first matching slot and the largest remaining job id.
module jt_scan #(
    parameter int SLOT_COUNT  = jt_pkg::SLOT_COUNT_DEF,
    parameter int JOB_ID_BITS = jt_pkg::JOB_ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  jt_pkg::scan_ctl_t             ctl,
    input  logic                          rd_vld,
    input  logic [$clog2(SLOT_COUNT)-1:0] rd_idx,
    input  logic [jt_pkg::PID_W-1:0]      rd_pid,
    input  logic [JOB_ID_BITS-1:0]        rd_jid,
    input  logic [jt_pkg::STATE_W-1:0]    rd_st,
    input  logic [jt_pkg::PID_W-1:0]      key_pid,
    input  logic [jt_pkg::JID_W-1:0]      key_jid,
    output logic                          hit,
    output logic [$clog2(SLOT_COUNT)-1:0] hit_idx,
    output logic [jt_pkg::PID_W-1:0]      hit_pid,
    output logic [JOB_ID_BITS-1:0]        hit_jid,
    output logic [jt_pkg::STATE_W-1:0]    hit_st,
    output logic [JOB_ID_BITS-1:0]        max_jid
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int JCW   = (JOB_ID_BITS > jt_pkg::JID_W) ? JOB_ID_BITS : jt_pkg::JID_W;

    logic                         match;
    logic                         first;
    logic [JCW-1:0]               rd_jid_ext;
    logic [JCW-1:0]               key_jid_ext;
    logic                         hit_reg;
    logic [JOB_ID_BITS-1:0]       max_reg;
    logic [IDX_W-1:0]             hit_idx_reg;
    logic [jt_pkg::PID_W-1:0]     hit_pid_reg;
    logic [JOB_ID_BITS-1:0]       hit_jid_reg;
    logic [jt_pkg::STATE_W-1:0]   hit_st_reg;

    assign rd_jid_ext  = JCW'(rd_jid);
    assign key_jid_ext = JCW'(key_jid);

    // Match rule for the command in progress
    always_comb
    begin
        case (ctl.kind)
            jt_pkg::KIND_ADD:                         match = (rd_pid == '0);
            jt_pkg::KIND_REMOVE, jt_pkg::KIND_FIND_PID: match = (rd_pid == key_pid);
            jt_pkg::KIND_FIND_JID:                    match = (rd_jid_ext == key_jid_ext);
            jt_pkg::KIND_FG:                          match = (rd_st == jt_pkg::ST_FG);
            default:                                  match = 1'b0;
        endcase
    end

    assign first = rd_vld && match && !hit_reg;

    // Hold first hit; fold every other entry into the running maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            max_reg <= '0;
        end
        else if (ctl.clear)
        begin
            hit_reg <= 1'b0;
            max_reg <= '0;
        end
        else if (rd_vld)
        begin
            if (first)
            begin
                hit_reg <= 1'b1;
            end
            else if (rd_jid > max_reg)
            begin
                max_reg <= rd_jid;
            end
        end
    end

    // Capture the first matching entry
    always_ff @(posedge clk)
    begin
        if (first)
        begin
            hit_idx_reg <= rd_idx;
            hit_pid_reg <= rd_pid;
            hit_jid_reg <= rd_jid;
            hit_st_reg  <= rd_st;
        end
    end

    assign hit     = hit_reg;
    assign hit_idx = hit_idx_reg;
    assign hit_pid = hit_pid_reg;
    assign hit_jid = hit_jid_reg;
    assign hit_st  = hit_st_reg;
    assign max_jid = max_reg;

endmodule

/* rtl/job_table_with_id_allocation_core.sv */
// Job table with job id allocation: one command in, one result out per transaction.
// The slot memory has one read port and every command reads all slots in order, one per
// cycle, then passes through a last-read state and a write-back and result state before
// the block is ready again. A command with a zero id or an unknown kind skips the scan
// and goes straight to write-back. The result sits in an output register, so the next
// command is accepted while a result still waits; a result not taken holds the block in
// its write-back state. After reset the table is empty and the next job id is 1; no
// clearing pass is needed.
module job_table_with_id_allocation_core #(
    parameter int SLOT_COUNT  = jt_pkg::SLOT_COUNT_DEF,
    parameter int JOB_ID_BITS = jt_pkg::JOB_ID_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [jt_pkg::KIND_W-1:0]   kind,
    input  logic [jt_pkg::PID_W-1:0]    process_id,
    input  logic [jt_pkg::JID_W-1:0]    job_id,
    input  logic [jt_pkg::STATE_W-1:0]  new_state,
    input  logic                        write_state,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [jt_pkg::STATUS_W-1:0] status,
    output logic [jt_pkg::PID_W-1:0]    found_process_id,
    output logic [jt_pkg::JID_W-1:0]    found_job_id,
    output logic [jt_pkg::STATE_W-1:0]  found_state
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int ENT_W = jt_pkg::PID_W + JOB_ID_BITS + jt_pkg::STATE_W;
    localparam int JW1   = JOB_ID_BITS + 1;
    localparam int CW    = (JW1 > 9) ? JW1 : 9;
    localparam int JPW   = (JOB_ID_BITS > jt_pkg::JID_W) ? JOB_ID_BITS : jt_pkg::JID_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST, S_UPDATE} state_t;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              rd_addr_reg, rd_addr_next;
    logic [JOB_ID_BITS-1:0]        next_jid_reg, next_jid_next;
    logic                          out_valid_reg, out_valid_next;
    logic [jt_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [jt_pkg::PID_W-1:0]      opid_reg, opid_next;
    logic [jt_pkg::JID_W-1:0]      ojid_reg, ojid_next;
    logic [jt_pkg::STATE_W-1:0]    ost_reg, ost_next;

    logic [jt_pkg::KIND_W-1:0]     kind_reg;
    logic [jt_pkg::PID_W-1:0]      pid_reg;
    logic [jt_pkg::JID_W-1:0]      jid_reg;
    logic [jt_pkg::STATE_W-1:0]    nst_reg;
    logic                          wr_reg;
    logic                          bad_reg;

    logic                          accept;
    logic                          in_bad;
    logic                          rd_en;
    logic                          rd_last;
    logic                          load;
    logic                          wr_en;
    logic [ENT_W-1:0]              wr_data;
    logic                          rd_vld;
    logic [IDX_W-1:0]              rd_idx;
    logic [ENT_W-1:0]              rd_data;
    jt_pkg::scan_ctl_t             scan_ctl;

    logic                          hit;
    logic [IDX_W-1:0]              hit_idx;
    logic [jt_pkg::PID_W-1:0]      hit_pid;
    logic [JOB_ID_BITS-1:0]        hit_jid;
    logic [jt_pkg::STATE_W-1:0]    hit_st;
    logic [JOB_ID_BITS-1:0]        max_jid;

    logic [CW-1:0]                 add_n;
    logic [JOB_ID_BITS-1:0]        add_id;
    logic [JW1-1:0]                rem_n;
    logic [JOB_ID_BITS-1:0]        rem_id;
    logic [JPW-1:0]                next_pad;
    logic [JPW-1:0]                hit_pad;

    // Handshake and command check
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        case (kind)
            jt_pkg::KIND_ADD, jt_pkg::KIND_REMOVE, jt_pkg::KIND_FIND_PID:
                in_bad = (process_id == '0);
            jt_pkg::KIND_FIND_JID:
                in_bad = (job_id == '0);
            jt_pkg::KIND_FG:
                in_bad = 1'b0;
            default:
                in_bad = 1'b1;
        endcase
    end

    // Scan read sequencing
    assign rd_en   = (state_reg == S_SCAN);
    assign rd_last = (rd_addr_reg == IDX_W'(SLOT_COUNT - 1));
    assign load    = (state_reg == S_UPDATE) && (!out_valid_reg || out_ready);

    assign scan_ctl.clear = accept;
    assign scan_ctl.kind  = kind_reg;

    jt_slot_ram #(
        .DEPTH  (SLOT_COUNT),
        .DATA_W (ENT_W)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (hit_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_vld  (rd_vld),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    jt_scan #(
        .SLOT_COUNT  (SLOT_COUNT),
        .JOB_ID_BITS (JOB_ID_BITS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .rd_vld  (rd_vld),
        .rd_idx  (rd_idx),
        .rd_pid  (rd_data[ENT_W-1 -: jt_pkg::PID_W]),
        .rd_jid  (rd_data[jt_pkg::STATE_W +: JOB_ID_BITS]),
        .rd_st   (rd_data[jt_pkg::STATE_W-1:0]),
        .key_pid (pid_reg),
        .key_jid (jid_reg),
        .hit     (hit),
        .hit_idx (hit_idx),
        .hit_pid (hit_pid),
        .hit_jid (hit_jid),
        .hit_st  (hit_st),
        .max_jid (max_jid)
    );

    // Next job id after an add: wrap past the slot count or the id range
    assign add_n  = CW'(next_jid_reg) + CW'(1);
    assign add_id = ((add_n > CW'(SLOT_COUNT)) || add_n[JOB_ID_BITS])
                    ? JOB_ID_BITS'(1) : add_n[JOB_ID_BITS-1:0];

    // Next job id after a remove: largest remaining id plus one
    assign rem_n  = JW1'(max_jid) + JW1'(1);
    assign rem_id = rem_n[JOB_ID_BITS] ? JOB_ID_BITS'(1) : rem_n[JOB_ID_BITS-1:0];

    assign next_pad = JPW'(next_jid_reg);
    assign hit_pad  = JPW'(hit_jid);

    // Sequencer, write-back and result
    always_comb
    begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        next_jid_next  = next_jid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        opid_next      = opid_reg;
        ojid_next      = ojid_reg;
        ost_next       = ost_reg;
        wr_en          = 1'b0;
        wr_data        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rd_addr_next = '0;
                    state_next   = in_bad ? S_UPDATE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_addr_next = rd_addr_reg + IDX_W'(1);
                if (rd_last)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (load)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = jt_pkg::STATUS_NOT_FOUND;
                    opid_next      = '0;
                    ojid_next      = '0;
                    ost_next       = jt_pkg::ST_NONE;
                    if (bad_reg)
                    begin
                        status_next = jt_pkg::STATUS_BAD_ID;
                    end
                    else
                    begin
                        case (kind_reg)
                            jt_pkg::KIND_ADD:
                            begin
                                if (hit)
                                begin
                                    status_next   = jt_pkg::STATUS_OK;
                                    opid_next     = pid_reg;
                                    ojid_next     = next_pad[jt_pkg::JID_W-1:0];
                                    wr_en         = 1'b1;
                                    wr_data       = {pid_reg, next_jid_reg, nst_reg};
                                    next_jid_next = add_id;
                                end
                                else
                                begin
                                    status_next = jt_pkg::STATUS_FULL;
                                end
                            end
                            jt_pkg::KIND_REMOVE:
                            begin
                                if (hit)
                                begin
                                    status_next   = jt_pkg::STATUS_OK;
                                    opid_next     = hit_pid;
                                    ojid_next     = hit_pad[jt_pkg::JID_W-1:0];
                                    ost_next      = hit_st;
                                    wr_en         = 1'b1;
                                    wr_data       = '0;
                                    next_jid_next = rem_id;
                                end
                            end
                            jt_pkg::KIND_FIND_PID, jt_pkg::KIND_FIND_JID:
                            begin
                                if (hit)
                                begin
                                    status_next = jt_pkg::STATUS_OK;
                                    opid_next   = hit_pid;
                                    ojid_next   = hit_pad[jt_pkg::JID_W-1:0];
                                    ost_next    = hit_st;
                                    wr_en       = wr_reg;
                                    wr_data     = {hit_pid, hit_jid, nst_reg};
                                end
                            end
                            jt_pkg::KIND_FG:
                            begin
                                if (hit)
                                begin
                                    status_next = jt_pkg::STATUS_OK;
                                    opid_next   = hit_pid;
                                end
                            end
                            default:
                            begin
                                status_next = jt_pkg::STATUS_BAD_ID;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, next id and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_addr_reg   <= '0;
            next_jid_reg  <= JOB_ID_BITS'(1);
            out_valid_reg <= 1'b0;
            status_reg    <= jt_pkg::STATUS_OK;
            opid_reg      <= '0;
            ojid_reg      <= '0;
            ost_reg       <= jt_pkg::ST_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            rd_addr_reg   <= rd_addr_next;
            next_jid_reg  <= next_jid_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            opid_reg      <= opid_next;
            ojid_reg      <= ojid_next;
            ost_reg       <= ost_next;
        end
    end

    // Capture the command on acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            pid_reg  <= process_id;
            jid_reg  <= job_id;
            nst_reg  <= new_state;
            wr_reg   <= write_state;
            bad_reg  <= in_bad;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign found_process_id = opid_reg;
    assign found_job_id     = ojid_reg;
    assign found_state      = ost_reg;

endmodule

/* rtl/jt_checker.sv */
// Port-level checks of the job table and their binding to the top level.
`include "job_table_with_id_allocation_core_macros.svh"

module jt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [jt_pkg::STATUS_W-1:0] status,
    input logic [jt_pkg::PID_W-1:0]    found_process_id,
    input logic [jt_pkg::JID_W-1:0]    found_job_id,
    input logic [jt_pkg::STATE_W-1:0]  found_state
);

    // One command at a time: busy right after a transaction
    `JT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // A stalled result holds
    `JT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(found_process_id) && $stable(found_job_id) && $stable(found_state))

    // A failed command returns empty fields
    `JT_ASSERT_IMP(a_fail_empty, out_valid && status != jt_pkg::STATUS_OK, found_process_id == '0 && found_job_id == '0 && found_state == '0)

    // A successful command always names a live process
    `JT_ASSERT_IMP(a_ok_pid, out_valid && status == jt_pkg::STATUS_OK, found_process_id != '0)

endmodule

bind job_table_with_id_allocation_core jt_checker u_jt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .found_process_id (found_process_id),
    .found_job_id     (found_job_id),
    .found_state      (found_state)
);
